// ===== hdl/bgps_pkg.sv =====
// ----------------------------------------------------------------------------
// bgps_pkg
// Shared types and constants of the BGP session state machine: state and
// event codes, action mask bits, register indexes and the result struct.
// ----------------------------------------------------------------------------
package bgps_pkg;

    // Session states
    typedef enum logic [2:0] {
        ST_IDLE        = 3'd0,
        ST_CONNECT     = 3'd1,
        ST_ACTIVE      = 3'd2,
        ST_OPENSENT    = 3'd3,
        ST_OPENCONFIRM = 3'd4,
        ST_ESTABLISHED = 3'd5
    } state_t;

    // Session events
    typedef enum logic [3:0] {
        EV_START         = 4'd0,
        EV_STOP          = 4'd1,
        EV_TCP_OPEN      = 4'd2,
        EV_TCP_CLOSED    = 4'd3,
        EV_TCP_FAILED    = 4'd4,
        EV_TCP_FATAL     = 4'd5,
        EV_RETRY_EXPIRED = 4'd6,
        EV_HOLD_EXPIRED  = 4'd7,
        EV_KA_EXPIRED    = 4'd8,
        EV_RX_OPEN       = 4'd9,
        EV_RX_KEEPALIVE  = 4'd10,
        EV_RX_UPDATE     = 4'd11,
        EV_RX_NOTIFY     = 4'd12
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_RETRY_LOAD = 2'd0,
        REG_HOLD_LOAD  = 2'd1,
        REG_KA_LOAD    = 2'd2
    } reg_idx_t;

    localparam int ACT_W   = 13;
    localparam int TIMER_W = 16;

    typedef logic [ACT_W-1:0]   act_t;
    typedef logic [TIMER_W-1:0] timer_t;

    // Action mask bits
    localparam act_t ACT_INIT         = act_t'(1) << 0;
    localparam act_t ACT_RELEASE      = act_t'(1) << 1;
    localparam act_t ACT_TCP_OPEN     = act_t'(1) << 2;
    localparam act_t ACT_TCP_DROP     = act_t'(1) << 3;
    localparam act_t ACT_COMPLETE     = act_t'(1) << 4;
    localparam act_t ACT_TX_OPEN      = act_t'(1) << 5;
    localparam act_t ACT_TX_KEEPALIVE = act_t'(1) << 6;
    localparam act_t ACT_TX_NOTIFY    = act_t'(1) << 7;
    localparam act_t ACT_TX_UPDATE    = act_t'(1) << 8;
    localparam act_t ACT_RETRY_START  = act_t'(1) << 9;
    localparam act_t ACT_RETRY_STOP   = act_t'(1) << 10;
    localparam act_t ACT_HOLD_RESTART = act_t'(1) << 11;
    localparam act_t ACT_KA_RESTART   = act_t'(1) << 12;

    localparam act_t ABORT_ACTS = ACT_TCP_DROP | ACT_RELEASE | ACT_TX_NOTIFY;

    localparam timer_t LOAD_RESET = timer_t'(120);

    // Timer load values held by the register file
    typedef struct packed {
        timer_t retry_load;
        timer_t hold_load;
        timer_t ka_load;
    } loads_t;

    // One result beat
    typedef struct packed {
        state_t next_state;
        logic   discarded;
        act_t   action_mask;
        timer_t timer_value;
    } result_t;

endpackage

// ===== hdl/bgps_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bgps_cfg_regs
// Timer load registers, written through a valid/ready port. Writes to an
// index outside the register list are taken and dropped.
// ----------------------------------------------------------------------------
module bgps_cfg_regs
    import bgps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    output loads_t       loads
);

    loads_t loads_reg;

    // Always able to take a write
    assign cfg_ready = 1'b1;

    // Update the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loads_reg.retry_load <= LOAD_RESET;
            loads_reg.hold_load  <= LOAD_RESET;
            loads_reg.ka_load    <= LOAD_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_RETRY_LOAD: loads_reg.retry_load <= cfg_data;
                REG_HOLD_LOAD:  loads_reg.hold_load  <= cfg_data;
                REG_KA_LOAD:    loads_reg.ka_load    <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign loads = loads_reg;

endmodule

// ===== hdl/bgps_fsm.sv =====
// ----------------------------------------------------------------------------
// bgps_fsm
// Session state register and transition logic. Decides one event per cycle
// when step is high and commits the new state at the same edge.
// ----------------------------------------------------------------------------
module bgps_fsm
    import bgps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [3:0]   cmd,
    input  logic         open_ok,
    input  logic         upd_ok,
    input  loads_t       loads,
    output result_t      res
);

    state_t state_reg;
    state_t state_next;
    act_t   acts;
    timer_t tv;
    logic   disc;

    // Hold the session state; advance on each decided event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

    // Transition table
    always_comb
    begin
        state_next = state_reg;
        acts       = '0;
        tv         = '0;
        disc       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_t'(cmd) == EV_START)
                begin
                    acts       = ACT_INIT | ACT_RETRY_START | ACT_TCP_OPEN;
                    tv         = loads.retry_load;
                    state_next = ST_CONNECT;
                end
                else
                begin
                    disc = 1'b1;
                end
            end

            ST_CONNECT, ST_ACTIVE:
            begin
                unique case (cmd_t'(cmd))
                    EV_START: disc = 1'b1;
                    EV_TCP_OPEN:
                    begin
                        acts       = ACT_COMPLETE | ACT_RETRY_STOP | ACT_TX_OPEN;
                        tv         = loads.retry_load;
                        state_next = ST_OPENSENT;
                    end
                    EV_TCP_FAILED:
                    begin
                        acts = ACT_RETRY_STOP | ACT_RETRY_START;
                        if (state_reg == ST_ACTIVE)
                        begin
                            acts = acts | ACT_TCP_DROP;
                        end
                        tv         = loads.retry_load;
                        state_next = ST_ACTIVE;
                    end
                    EV_RETRY_EXPIRED:
                    begin
                        acts       = ACT_RETRY_STOP | ACT_RETRY_START | ACT_TCP_OPEN;
                        tv         = loads.retry_load;
                        state_next = ST_CONNECT;
                    end
                    EV_STOP, EV_TCP_CLOSED, EV_TCP_FATAL, EV_HOLD_EXPIRED,
                    EV_KA_EXPIRED, EV_RX_OPEN, EV_RX_KEEPALIVE, EV_RX_UPDATE,
                    EV_RX_NOTIFY:
                    begin
                        acts       = ACT_RELEASE;
                        state_next = ST_IDLE;
                    end
                    default: disc = 1'b1;
                endcase
            end

            ST_OPENSENT:
            begin
                unique case (cmd_t'(cmd))
                    EV_START: disc = 1'b1;
                    EV_TCP_CLOSED:
                    begin
                        acts       = ACT_TCP_DROP | ACT_RETRY_STOP | ACT_RETRY_START;
                        tv         = loads.retry_load;
                        state_next = ST_ACTIVE;
                    end
                    EV_TCP_FATAL:
                    begin
                        acts       = ACT_RELEASE;
                        state_next = ST_IDLE;
                    end
                    EV_RX_OPEN:
                    begin
                        if (open_ok)
                        begin
                            acts       = ACT_TX_KEEPALIVE;
                            state_next = ST_OPENCONFIRM;
                        end
                        else
                        begin
                            acts       = ACT_TX_NOTIFY;
                            state_next = ST_IDLE;
                        end
                    end
                    EV_STOP, EV_TCP_OPEN, EV_TCP_FAILED, EV_RETRY_EXPIRED,
                    EV_HOLD_EXPIRED, EV_KA_EXPIRED, EV_RX_KEEPALIVE,
                    EV_RX_UPDATE, EV_RX_NOTIFY:
                    begin
                        acts       = ABORT_ACTS;
                        state_next = ST_IDLE;
                    end
                    default: disc = 1'b1;
                endcase
            end

            ST_OPENCONFIRM:
            begin
                unique case (cmd_t'(cmd))
                    EV_START: disc = 1'b1;
                    EV_TCP_CLOSED, EV_TCP_FATAL:
                    begin
                        acts       = ACT_RELEASE;
                        state_next = ST_IDLE;
                    end
                    EV_KA_EXPIRED:
                    begin
                        acts       = ACT_KA_RESTART;
                        tv         = loads.ka_load;
                        state_next = ST_OPENCONFIRM;
                    end
                    EV_RX_KEEPALIVE:
                    begin
                        acts       = ACT_COMPLETE | ACT_HOLD_RESTART;
                        tv         = loads.hold_load;
                        state_next = ST_ESTABLISHED;
                    end
                    EV_RX_NOTIFY:
                    begin
                        acts       = ACT_TCP_DROP | ACT_RELEASE;
                        state_next = ST_IDLE;
                    end
                    EV_STOP, EV_TCP_OPEN, EV_TCP_FAILED, EV_RETRY_EXPIRED,
                    EV_HOLD_EXPIRED, EV_RX_OPEN, EV_RX_UPDATE:
                    begin
                        acts       = ABORT_ACTS;
                        state_next = ST_IDLE;
                    end
                    default: disc = 1'b1;
                endcase
            end

            ST_ESTABLISHED:
            begin
                unique case (cmd_t'(cmd))
                    EV_START, EV_TCP_CLOSED, EV_TCP_FATAL, EV_KA_EXPIRED:
                    begin
                        disc = 1'b1;
                    end
                    EV_RX_KEEPALIVE:
                    begin
                        acts       = ACT_HOLD_RESTART;
                        tv         = loads.hold_load;
                        state_next = ST_ESTABLISHED;
                    end
                    EV_RX_UPDATE:
                    begin
                        if (upd_ok)
                        begin
                            acts       = ACT_TX_UPDATE;
                            state_next = ST_ESTABLISHED;
                        end
                        else
                        begin
                            acts       = ACT_TX_NOTIFY;
                            state_next = ST_IDLE;
                        end
                    end
                    EV_RX_NOTIFY:
                    begin
                        acts       = ACT_TCP_DROP | ACT_RELEASE;
                        state_next = ST_IDLE;
                    end
                    EV_STOP, EV_TCP_OPEN, EV_TCP_FAILED, EV_RETRY_EXPIRED,
                    EV_HOLD_EXPIRED, EV_RX_OPEN:
                    begin
                        acts       = ABORT_ACTS;
                        state_next = ST_IDLE;
                    end
                    default: disc = 1'b1;
                endcase
            end

            // Unused state codes: drop every event
            default: disc = 1'b1;
        endcase

        // A dropped event keeps the state and requests nothing
        if (disc)
        begin
            state_next = state_reg;
            acts       = '0;
            tv         = '0;
        end
    end

    assign res.next_state  = state_next;
    assign res.discarded   = disc;
    assign res.action_mask = acts;
    assign res.timer_value = tv;

    // A dropped event leaves the state untouched
    a_disc_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        step && disc |=> state_reg == $past(state_reg))
        else $error("dropped event changed session state");

    // A timer value only comes with a timer action
    a_tv_has_timer: assert property (@(posedge clk) disable iff (!rst_n)
        tv != '0 |-> (acts & (ACT_RETRY_START | ACT_RETRY_STOP |
                              ACT_HOLD_RESTART | ACT_KA_RESTART)) != '0)
        else $error("timer value without timer action");

    // The committed state is the one reported
    a_state_follows: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> state_reg == $past(state_next))
        else $error("state register does not follow reported next state");

endmodule

// ===== hdl/bgp_session_fsm.sv =====
// ----------------------------------------------------------------------------
// bgp_session_fsm
// BGP session state machine: one event beat in, one result beat out.
// ----------------------------------------------------------------------------
// Pipeline: an accepted event beat passes the input register, then the result
// register, on its way to the outputs.
// Throughput: one event per cycle while the result side does not stall; the session
// state loop closes through the transition table between input and result registers.
// Reset: session state Idle, all timer loads 120, both pipeline stages empty.
// ----------------------------------------------------------------------------
module bgp_session_fsm
    import bgps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // Event channel
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [3:0]   cmd,
    input  logic         open_accepted,
    input  logic         update_accepted,
    // Result channel
    output logic         out_valid,
    input  logic         out_stall,
    output logic [2:0]   next_state,
    output logic         discarded,
    output logic [12:0]  action_mask,
    output logic [15:0]  timer_value,
    // Configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    logic        in_valid_reg;
    logic [3:0]  cmd_reg;
    logic        open_ok_reg;
    logic        upd_ok_reg;
    logic        out_valid_reg;
    result_t     res_reg;
    result_t     res;
    loads_t      loads;
    logic        out_adv;
    logic        step;

    // Result register advances when empty or taken downstream
    assign out_adv  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && out_adv;
    assign in_stall = in_valid_reg && !out_adv;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            cmd_reg     <= cmd;
            open_ok_reg <= open_accepted;
            upd_ok_reg  <= update_accepted;
        end
    end

    // Timer load registers
    bgps_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .loads     (loads)
    );

    // Transition logic and session state
    bgps_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .cmd     (cmd_reg),
        .open_ok (open_ok_reg),
        .upd_ok  (upd_ok_reg),
        .loads   (loads),
        .res     (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign next_state  = res_reg.next_state;
    assign discarded   = res_reg.discarded;
    assign action_mask = res_reg.action_mask;
    assign timer_value = res_reg.timer_value;

    // A decided event always lands in the result register
    a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("decided event did not reach result register");

endmodule

// ===== sim/tb_bgp_session_fsm.sv =====
// ----------------------------------------------------------------------------
// tb_bgp_session_fsm
// Self-checking bench for the BGP session state machine. A directed walk
// through every session state, with most events, is followed by phases of random,
// mostly well-formed session traffic under several timer load settings.
// Every result beat is compared field by field with an in-order prediction.
// ----------------------------------------------------------------------------
module tb_bgp_session_fsm;
    import bgps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 4;
    localparam int N_PHASES        = 6;
    localparam int PHASE_ACTED     = 210;

    // Event codes beyond the defined set
    localparam logic [3:0] EV_RSVD13 = 4'd13;
    localparam logic [3:0] EV_RSVD14 = 4'd14;
    localparam logic [3:0] EV_RSVD15 = 4'd15;

    // Register index with no register behind it
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [3:0] ev;
        logic       oa;
        logic       ua;
        bit         pinned;
        result_t    res;
    } event_row_t;

    typedef struct {
        logic [3:0] ev;
        logic       oa;
        logic       ua;
    } event_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [3:0]  cmd;
    logic        open_accepted;
    logic        update_accepted;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  next_state;
    logic        discarded;
    logic [12:0] action_mask;
    logic [15:0] timer_value;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // Shadow of the session and the timer loads
    state_t  sess_state = ST_IDLE;
    timer_t  retry_load = LOAD_RESET;
    timer_t  hold_ld    = LOAD_RESET;
    timer_t  ka_load    = LOAD_RESET;

    result_t    session_results_q[$];
    event_row_t event_rows[$];

    bit      drv_pinned;
    result_t drv_pinned_res;
    bit      pace_on;
    bit      hold_off_req;
    int      errors;
    int      acted_cnt;
    int      idle_cycles;

    bgp_session_fsm DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .open_accepted   (open_accepted),
        .update_accepted (update_accepted),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .next_state      (next_state),
        .discarded       (discarded),
        .action_mask     (action_mask),
        .timer_value     (timer_value),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Compute the session transition and advance the shadow state
    function automatic result_t next_session(input logic [3:0] ev, input logic oa,
                                             input logic ua);
        result_t r;
        r.next_state  = sess_state;
        r.discarded   = 1'b0;
        r.action_mask = '0;
        r.timer_value = '0;
        if (ev > EV_RX_NOTIFY)
        begin
            r.discarded = 1'b1;
        end
        else
        begin
            case (sess_state)
                ST_IDLE:
                begin
                    if (ev == EV_START)
                    begin
                        r.action_mask = ACT_INIT | ACT_RETRY_START | ACT_TCP_OPEN;
                        r.timer_value = retry_load;
                        r.next_state  = ST_CONNECT;
                    end
                    else
                    begin
                        r.discarded = 1'b1;
                    end
                end
                ST_CONNECT, ST_ACTIVE:
                begin
                    case (ev)
                        EV_START: r.discarded = 1'b1;
                        EV_TCP_OPEN:
                        begin
                            r.action_mask = ACT_COMPLETE | ACT_RETRY_STOP | ACT_TX_OPEN;
                            r.timer_value = retry_load;
                            r.next_state  = ST_OPENSENT;
                        end
                        EV_TCP_FAILED:
                        begin
                            r.action_mask = ACT_RETRY_STOP | ACT_RETRY_START;
                            if (sess_state == ST_ACTIVE)
                                r.action_mask |= ACT_TCP_DROP;
                            r.timer_value = retry_load;
                            r.next_state  = ST_ACTIVE;
                        end
                        EV_RETRY_EXPIRED:
                        begin
                            r.action_mask = ACT_RETRY_STOP | ACT_RETRY_START | ACT_TCP_OPEN;
                            r.timer_value = retry_load;
                            r.next_state  = ST_CONNECT;
                        end
                        default:
                        begin
                            r.action_mask = ACT_RELEASE;
                            r.next_state  = ST_IDLE;
                        end
                    endcase
                end
                ST_OPENSENT:
                begin
                    case (ev)
                        EV_START: r.discarded = 1'b1;
                        EV_TCP_CLOSED:
                        begin
                            r.action_mask = ACT_TCP_DROP | ACT_RETRY_STOP | ACT_RETRY_START;
                            r.timer_value = retry_load;
                            r.next_state  = ST_ACTIVE;
                        end
                        EV_TCP_FATAL:
                        begin
                            r.action_mask = ACT_RELEASE;
                            r.next_state  = ST_IDLE;
                        end
                        EV_RX_OPEN:
                        begin
                            // rejected OPEN only notifies and drops to Idle
                            r.action_mask = oa ? ACT_TX_KEEPALIVE : ACT_TX_NOTIFY;
                            r.next_state  = oa ? ST_OPENCONFIRM : ST_IDLE;
                        end
                        default:
                        begin
                            r.action_mask = ABORT_ACTS;
                            r.next_state  = ST_IDLE;
                        end
                    endcase
                end
                ST_OPENCONFIRM:
                begin
                    case (ev)
                        EV_START: r.discarded = 1'b1;
                        EV_TCP_CLOSED, EV_TCP_FATAL:
                        begin
                            r.action_mask = ACT_RELEASE;
                            r.next_state  = ST_IDLE;
                        end
                        EV_KA_EXPIRED:
                        begin
                            r.action_mask = ACT_KA_RESTART;
                            r.timer_value = ka_load;
                        end
                        EV_RX_KEEPALIVE:
                        begin
                            r.action_mask = ACT_COMPLETE | ACT_HOLD_RESTART;
                            r.timer_value = hold_ld;
                            r.next_state  = ST_ESTABLISHED;
                        end
                        EV_RX_NOTIFY:
                        begin
                            r.action_mask = ACT_TCP_DROP | ACT_RELEASE;
                            r.next_state  = ST_IDLE;
                        end
                        default:
                        begin
                            r.action_mask = ABORT_ACTS;
                            r.next_state  = ST_IDLE;
                        end
                    endcase
                end
                ST_ESTABLISHED:
                begin
                    case (ev)
                        EV_START, EV_TCP_CLOSED, EV_TCP_FATAL, EV_KA_EXPIRED:
                            r.discarded = 1'b1;
                        EV_RX_KEEPALIVE:
                        begin
                            r.action_mask = ACT_HOLD_RESTART;
                            r.timer_value = hold_ld;
                        end
                        EV_RX_UPDATE:
                        begin
                            // rejected UPDATE only notifies and drops to Idle
                            r.action_mask = ua ? ACT_TX_UPDATE : ACT_TX_NOTIFY;
                            r.next_state  = ua ? ST_ESTABLISHED : ST_IDLE;
                        end
                        EV_RX_NOTIFY:
                        begin
                            r.action_mask = ACT_TCP_DROP | ACT_RELEASE;
                            r.next_state  = ST_IDLE;
                        end
                        default:
                        begin
                            r.action_mask = ABORT_ACTS;
                            r.next_state  = ST_IDLE;
                        end
                    endcase
                end
                default: r.discarded = 1'b1;
            endcase
        end
        // Ignored events keep the state and request nothing
        if (r.discarded)
        begin
            r.next_state  = sess_state;
            r.action_mask = '0;
            r.timer_value = '0;
        end
        sess_state = r.next_state;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
        end
    endfunction

    // Gap length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        if (!pace_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Pick the next event: mostly one that moves the session along
    function automatic event_t pick_event();
        event_t e;
        int     r;
        r    = $urandom_range(0, 99);
        e.oa = 1'($urandom_range(0, 1));
        e.ua = 1'($urandom_range(0, 1));
        e.ev = 4'($urandom_range(0, 12));
        if ($urandom_range(0, 99) < 15)
        begin
            e.ev = 4'($urandom_range(0, 15));
            return e;
        end
        case (sess_state)
            ST_IDLE:
                if (r < 85) e.ev = EV_START;
            ST_CONNECT, ST_ACTIVE:
                if (r < 55)      e.ev = EV_TCP_OPEN;
                else if (r < 70) e.ev = EV_TCP_FAILED;
                else if (r < 85) e.ev = EV_RETRY_EXPIRED;
            ST_OPENSENT:
                if (r < 75)
                begin
                    e.ev = EV_RX_OPEN;
                    e.oa = ($urandom_range(0, 99) < 85);
                end
                else if (r < 85)
                begin
                    e.ev = EV_TCP_CLOSED;
                end
            ST_OPENCONFIRM:
                if (r < 55)      e.ev = EV_RX_KEEPALIVE;
                else if (r < 80) e.ev = EV_KA_EXPIRED;
            ST_ESTABLISHED:
                if (r < 50)
                begin
                    e.ev = EV_RX_UPDATE;
                    e.ua = ($urandom_range(0, 99) < 90);
                end
                else if (r < 75)
                begin
                    e.ev = EV_RX_KEEPALIVE;
                end
                else if (r < 85)
                begin
                    e.ev = EV_KA_EXPIRED;
                end
            default: ;
        endcase
        return e;
    endfunction

    task automatic add_row(input logic [3:0] ev, input logic oa, input logic ua,
                           input bit pinned, input state_t st, input logic disc,
                           input act_t mask, input timer_t tv);
        event_row_t row;
        row.ev                = ev;
        row.oa                = oa;
        row.ua                = ua;
        row.pinned            = pinned;
        row.res.next_state    = st;
        row.res.discarded     = disc;
        row.res.action_mask   = mask;
        row.res.timer_value   = tv;
        event_rows.push_back(row);
    endtask

    // Offer one event beat; entered and left at a falling edge
    task automatic send_event(input logic [3:0] ev, input logic oa, input logic ua,
                              input bit pinned, input result_t pin_res);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid        <= 1'b1;
        cmd             <= ev;
        open_accepted   <= oa;
        update_accepted <= ua;
        drv_pinned      = pinned;
        drv_pinned_res  = pin_res;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input timer_t val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_timers(input timer_t retry, input timer_t hold, input timer_t ka);
        write_reg(REG_RETRY_LOAD, retry);
        write_reg(REG_HOLD_LOAD, hold);
        write_reg(REG_KA_LOAD, ka);
    endtask

    // Drop valid and wait until every result is back and the pipe is empty
    task automatic end_phase();
        in_valid <= 1'b0;
        while (session_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Predict on accepted events, check accepted results, track register writes
    always @(posedge clk)
    begin
        result_t want;
        result_t pred;
        if (rst_n)
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (session_results_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat with no expectation, state %0d mask 0x%0h",
                             $time, next_state, action_mask);
                end
                else
                begin
                    want = session_results_q.pop_front();
                    check_field("next_state", 16'(want.next_state), 16'(next_state));
                    check_field("discarded", 16'(want.discarded), 16'(discarded));
                    check_field("action_mask", 16'(want.action_mask), 16'(action_mask));
                    check_field("timer_value", want.timer_value, timer_value);
                end
            end
            if (in_valid === 1'b1 && in_stall === 1'b0)
            begin
                pred = next_session(cmd, open_accepted, update_accepted);
                if (!pred.discarded)
                    acted_cnt++;
                session_results_q.push_back(drv_pinned ? drv_pinned_res : pred);
            end
            if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
            begin
                case (cfg_index)
                    REG_RETRY_LOAD: retry_load = cfg_data;
                    REG_HOLD_LOAD:  hold_ld    = cfg_data;
                    REG_KA_LOAD:    ka_load    = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            else if (!pace_on || $urandom_range(0, 1) == 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat (idle_len() + 1) @(negedge clk);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0) ||
                (cfg_valid === 1'b1 && cfg_ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Main sequence
    initial
    begin
        event_t e;
        int     goal;
        int     n;

        rst_n           = 1'b0;
        in_valid        = 1'b0;
        cmd             = '0;
        open_accepted   = 1'b0;
        update_accepted = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        drv_pinned      = 1'b0;
        drv_pinned_res  = '0;
        pace_on         = 1'b1;
        hold_off_req    = 1'b0;
        errors          = 0;
        acted_cnt       = 0;

        // Directed walk with reset timer loads
        add_row(EV_STOP, 1'b1, 1'b1, 1, ST_IDLE, 1'b1, '0, '0);
        add_row(EV_RSVD15, 1'b1, 1'b1, 1, ST_IDLE, 1'b1, '0, '0);
        add_row(EV_START, 1'b0, 1'b0, 1, ST_CONNECT, 1'b0,
                ACT_INIT | ACT_RETRY_START | ACT_TCP_OPEN, LOAD_RESET);
        add_row(EV_START, 1'b0, 1'b0, 1, ST_CONNECT, 1'b1, '0, '0);
        add_row(EV_RSVD13, 1'b0, 1'b1, 0, ST_IDLE, 1'b0, '0, '0);
        add_row(EV_TCP_FAILED, 1'b1, 1'b0, 0, ST_IDLE, 1'b0, '0, '0);
        add_row(EV_TCP_FAILED, 1'b0, 1'b0, 0, ST_IDLE, 1'b0, '0, '0);
        add_row(EV_RETRY_EXPIRED, 1'b0, 1'b0, 0, ST_IDLE, 1'b0, '0, '0);
        add_row(EV_TCP_OPEN, 1'b0, 1'b0, 0, ST_IDLE, 1'b0, '0, '0);
        add_row(EV_RX_OPEN, 1'b0, 1'b1, 1, ST_IDLE, 1'b0, ACT_TX_NOTIFY, '0);
        add_row(EV_START, 1'b0, 1'b0, 0, ST_IDLE, 1'b0, '0, '0);
        add_row(EV_TCP_OPEN, 1'b0, 1'b0, 0, ST_IDLE, 1'b0, '0, '0);
        add_row(EV_RX_OPEN, 1'b1, 1'b1, 0, ST_IDLE, 1'b0, '0, '0);
        add_row(EV_KA_EXPIRED, 1'b0, 1'b0, 0, ST_IDLE, 1'b0, '0, '0);
        add_row(EV_RX_KEEPALIVE, 1'b0, 1'b0, 0, ST_IDLE, 1'b0, '0, '0);
        add_row(EV_RX_UPDATE, 1'b0, 1'b1, 0, ST_IDLE, 1'b0, '0, '0);
        add_row(EV_RX_KEEPALIVE, 1'b1, 1'b0, 0, ST_IDLE, 1'b0, '0, '0);
        add_row(EV_KA_EXPIRED, 1'b0, 1'b0, 0, ST_IDLE, 1'b0, '0, '0);
        add_row(EV_RSVD14, 1'b1, 1'b1, 0, ST_IDLE, 1'b0, '0, '0);
        add_row(EV_RX_UPDATE, 1'b1, 1'b0, 1, ST_IDLE, 1'b0, ACT_TX_NOTIFY, '0);
        add_row(EV_START, 1'b0, 1'b0, 0, ST_IDLE, 1'b0, '0, '0);
        add_row(EV_TCP_OPEN, 1'b0, 1'b0, 0, ST_IDLE, 1'b0, '0, '0);
        add_row(EV_RX_OPEN, 1'b1, 1'b0, 0, ST_IDLE, 1'b0, '0, '0);
        add_row(EV_RX_NOTIFY, 1'b0, 1'b0, 0, ST_IDLE, 1'b0, '0, '0);

        // Hold reset, then release it at a falling edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        foreach (event_rows[i])
            send_event(event_rows[i].ev, event_rows[i].oa, event_rows[i].ua,
                       event_rows[i].pinned, event_rows[i].res);
        end_phase();

        // Random phases, each under its own timer loads
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0: load_timers(16'h0000, 16'h0000, 16'h0000);
                1: load_timers(16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: load_timers(16'hAAAA, 16'h5555, 16'hAAAA);
                3: load_timers(16'h5555, 16'hAAAA, 16'h5555);
                default:
                begin
                    write_reg(REG_UNUSED, timer_t'($urandom));
                    load_timers(timer_t'($urandom), timer_t'($urandom), timer_t'($urandom));
                end
            endcase
            // Back up the result side so the event side stalls
            if (ph == 2)
                hold_off_req = 1'b1;
            @(negedge clk);
            goal = acted_cnt + PHASE_ACTED;
            n    = 0;
            while (acted_cnt < goal)
            begin
                if (n % 64 == 0)
                    pace_on = ($urandom_range(0, 3) != 0);
                e = pick_event();
                send_event(e.ev, e.oa, e.ua, 1'b0, '0);
                n++;
            end
            end_phase();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
